// ===== design/lufd_pkg.sv =====
// ----------------------------------------------------------------------------
// lufd_pkg
// shared widths, register indexes and reset values of the file dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package lufd_pkg;

  localparam int unsigned SIZE_W    = 24;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DONE_W    = 5;
  localparam int unsigned STREAM_W  = 2;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned FCOUNT_W  = 6;
  localparam int unsigned CHOSEN_W  = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_3     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MASK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd6;

  localparam int unsigned POOL_REGS = 4;

  localparam logic [FCOUNT_W-1:0] FILE_COUNT_RST = 6'd32;
  localparam logic [TIME_W-1:0]   TIMEOUT_RST    = 32'd1000;

  // input item modes
  localparam logic MODE_REQUEST  = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

endpackage

`default_nettype wire

// ===== design/lufd_if.sv =====
// ----------------------------------------------------------------------------
// lufd channel interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lufd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [lufd_pkg::STREAM_W-1:0]  stream_index;
  logic [lufd_pkg::SIZE_W-1:0]    block_size;
  logic [lufd_pkg::TAG_W-1:0]     buffer_tag;
  logic [lufd_pkg::TIME_W-1:0]    now_time;
  logic [lufd_pkg::DONE_W-1:0]    done_file;

  modport source (output valid, mode, stream_index, block_size, buffer_tag, now_time,
                  done_file, input ready);
  modport sink   (input valid, mode, stream_index, block_size, buffer_tag, now_time,
                  done_file, output ready);
endinterface

interface lufd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [lufd_pkg::CHOSEN_W-1:0]  chosen_file;
  logic [lufd_pkg::SIZE_W-1:0]    dispatched_size;
  logic [lufd_pkg::TAG_W-1:0]     dispatched_tag;
  logic [lufd_pkg::MASK_W-1:0]    timeout_flags;

  modport source (output valid, accepted, chosen_file, dispatched_size, dispatched_tag,
                  timeout_flags, input ready);
  modport sink   (input valid, accepted, chosen_file, dispatched_size, dispatched_tag,
                  timeout_flags, output ready);
endinterface

interface lufd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lufd_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [lufd_pkg::CFG_DAT_W-1:0]  reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

// ===== design/lufd_cell.sv =====
// ----------------------------------------------------------------------------
// lufd_cell
// one file slot: holds its counters and flags, folds itself into the scan token
// ----------------------------------------------------------------------------
`default_nettype none

module lufd_cell #(
  parameter int unsigned FW  = 5,
  parameter int unsigned NW  = 6,
  parameter int unsigned CW  = 48,
  parameter int unsigned IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [FW+NW+CW+FW+FW+NW+2:0]  tok_i,
  output      logic [FW+NW+CW+FW+FW+NW+2:0]  tok_o,
  input  wire logic [NW+FW+64-1:0]           scan_i,
  input  wire logic [FW+lufd_pkg::SIZE_W+lufd_pkg::TIME_W+1:0] cmd_i,
  input  wire logic                          pool_i,
  input  wire logic                          open_i,
  output      logic                          timeout_o
);
  import lufd_pkg::*;

  typedef struct packed {
    logic          vld;
    logic          found;
    logic [FW-1:0] best_idx;
    logic [CW-1:0] best_cnt;
    logic [FW-1:0] best_pos;
    logic          nx_found;
    logic [FW-1:0] nx_idx;
    logic [NW-1:0] nx_key;
    logic [NW-1:0] spare;
  } tok_t;

  typedef struct packed {
    logic [NW-1:0]     n;
    logic [FW-1:0]     start;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] timeout;
  } scan_t;

  typedef struct packed {
    logic              dispatch;
    logic              complete;
    logic [FW-1:0]     idx;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] now;
  } cmd_t;

  tok_t  tin, tok_d, tok_q;
  scan_t sc;
  cmd_t  cmd;

  logic [CW-1:0]     cnt_q;
  logic              busy_q, pend_q, to_q;
  logic [TIME_W-1:0] stime_q;

  logic              in_range, elig, better, in_pool, nx_better, expired, hit;
  logic [NW:0]       pos_wide;
  logic [FW-1:0]     pos;
  logic [NW-1:0]     key;
  logic [TIME_W:0]   deadline;
  logic [CW:0]       sum;

  assign tin = tok_t'(tok_i);
  assign sc  = scan_t'(scan_i);
  assign cmd = cmd_t'(cmd_i);

  always_comb begin
    in_range = (NW+1)'(IDX) < {1'b0, sc.n};
    if (FW'(IDX) >= sc.start) begin
      pos_wide = (NW+1)'(IDX) - (NW+1)'(sc.start);
    end else begin
      pos_wide = (NW+1)'(IDX) + {1'b0, sc.n} - (NW+1)'(sc.start);
    end
    pos = pos_wide[FW-1:0];
    // distance from the start point for the next-start search, start itself last
    key = (pos == '0) ? sc.n : NW'(pos);

    elig    = tin.vld && in_range && pool_i && open_i && !busy_q;
    better  = !tin.found || (cnt_q < tin.best_cnt) ||
              ((cnt_q == tin.best_cnt) && (pos < tin.best_pos));
    in_pool = tin.vld && in_range && pool_i;
    nx_better = !tin.nx_found || (key < tin.nx_key);

    deadline = {1'b0, stime_q} + {1'b0, sc.timeout};
    expired  = in_pool && pend_q && ({1'b0, sc.now} > deadline);

    tok_d = tin;
    if (elig && better) begin
      tok_d.found    = 1'b1;
      tok_d.best_idx = FW'(IDX);
      tok_d.best_cnt = cnt_q;
      tok_d.best_pos = pos;
    end
    if (in_pool && nx_better) begin
      tok_d.nx_found = 1'b1;
      tok_d.nx_idx   = FW'(IDX);
      tok_d.nx_key   = key;
    end

    hit = (cmd.idx == FW'(IDX));
    sum = {1'b0, cnt_q} + (CW+1)'(cmd.size);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      to_q   <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (expired) begin
        to_q <= 1'b1;
      end
      if (cmd.dispatch && hit) begin
        busy_q <= 1'b1;
        pend_q <= 1'b1;
        cnt_q  <= sum[CW] ? '1 : sum[CW-1:0];
      end else if (cmd.complete && hit) begin
        busy_q <= 1'b0;
        pend_q <= 1'b0;
      end
    end
  end

  // start time has no reset, it is stamped before any read
  always_ff @(posedge clk_i) begin
    if (cmd.dispatch && hit) begin
      stime_q <= cmd.now;
    end else if (expired) begin
      stime_q <= sc.now;
    end
  end

  assign tok_o     = tok_q;
  assign timeout_o = to_q;

endmodule

`default_nettype wire

// ===== design/least_used_file_dispatcher.sv =====
// ----------------------------------------------------------------------------
// least_used_file_dispatcher
// least-loaded file selection with a rotating tie-break start per stream
// ----------------------------------------------------------------------------
// A write request is routed to the open, idle file of its stream's pool that
// holds the fewest bytes; ties go to the first file counting from the stream's
// rotating start point. Each file lives in a cell of a chain; a scan token
// enters the first cell and moves one cell per clock, picking up the best
// candidate, the next start point and setting timeout flags on the way. A
// request passes acceptance, then reduction of the stored start point by the
// file count while it is not below that count (only after the file count
// shrank), then the chain walk, commit and result load; commit is skipped when
// no file is ready. A completion goes from acceptance to commit and result
// load, and a request with a zero file count straight to result load. One
// transaction is in work at a time; a new one is taken while the previous
// result still waits on the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module least_used_file_dispatcher #(
  parameter int unsigned MAX_FILES   = 32,
  parameter int unsigned STREAMS     = 4,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lufd_in_if.sink    in_i,
  lufd_out_if.source out_o,
  lufd_cfg_if.sink   cfg_i
);
  import lufd_pkg::*;

  localparam int unsigned FW = $clog2(MAX_FILES);
  localparam int unsigned NW = $clog2(MAX_FILES + 1);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CMT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  typedef struct packed {
    logic          vld;
    logic          found;
    logic [FW-1:0] best_idx;
    logic [CW-1:0] best_cnt;
    logic [FW-1:0] best_pos;
    logic          nx_found;
    logic [FW-1:0] nx_idx;
    logic [NW-1:0] nx_key;
    logic [NW-1:0] spare;
  } tok_t;

  typedef struct packed {
    logic [NW-1:0]     n;
    logic [FW-1:0]     start;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] timeout;
  } scan_t;

  typedef struct packed {
    logic              dispatch;
    logic              complete;
    logic [FW-1:0]     idx;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // configuration registers
  logic [FCOUNT_W-1:0] fcount_q;
  logic [MASK_W-1:0]   pool_q [STREAMS];
  logic [MASK_W-1:0]   open_q;
  logic [TIME_W-1:0]   tmo_q;

  // per-stream rotating start points
  logic [FW-1:0] sstart_q [STREAMS];

  // sequencer and item registers
  logic [2:0]        state_q, state_d;
  logic              mode_q;
  logic [SIZE_W-1:0] size_q;
  logic [TAG_W-1:0]  tag_q;
  logic [TIME_W-1:0] now_q;
  logic [DONE_W-1:0] done_q;
  logic [FW-1:0]     start_q;
  logic [MASK_W-1:0] psel_q;
  logic              found_q;
  logic [FW-1:0]     best_q;
  logic [FW-1:0]     next_q;

  // output register
  logic                out_vld_q;
  logic                acc_q;
  logic [CHOSEN_W-1:0] chosen_q;
  logic [SIZE_W-1:0]   osize_q;
  logic [TAG_W-1:0]    otag_q;
  logic [MASK_W-1:0]   oflags_q;

  logic [NW-1:0] n_w;
  logic          in_fire, stream_ok, done_ok, inject, tail_vld;
  logic          out_free;
  tok_t          tok [MAX_FILES+1];
  tok_t          tail;
  scan_t         scan;
  cmd_t          cmd;
  logic [MAX_FILES-1:0] to_bits;
  logic [MASK_W-1:0]    flags_w;

  // files in use, clamped to the chain length
  assign n_w = ({1'b0, fcount_q} > (FCOUNT_W+1)'(MAX_FILES)) ? NW'(MAX_FILES)
                                                             : NW'(fcount_q);

  assign in_fire   = in_i.valid && in_i.ready;
  assign stream_ok = 32'(in_i.stream_index) < STREAMS;
  assign done_ok   = 32'(done_q) < MAX_FILES;
  assign out_free  = !out_vld_q || out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // configuration writes, index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= FILE_COUNT_RST;
      open_q   <= '0;
      tmo_q    <= TIMEOUT_RST;
      for (int k = 0; k < STREAMS; k++) begin
        pool_q[k] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_FILE_COUNT: fcount_q <= cfg_i.reg_data[FCOUNT_W-1:0];
        REG_POOL_0, REG_POOL_1, REG_POOL_2, REG_POOL_3: begin
          for (int k = 0; k < STREAMS; k++) begin
            if ((k < POOL_REGS) && (cfg_i.reg_index == CFG_IDX_W'(k + 1))) begin
              pool_q[k] <= cfg_i.reg_data;
            end
          end
        end
        REG_OPEN_MASK:  open_q <= cfg_i.reg_data;
        REG_TIMEOUT:    tmo_q  <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  // scan token injected once the start point is below the file count
  assign inject = (state_q == ST_NORM) && ({1'b0, start_q} < (FW+1)'(n_w));

  always_comb begin
    tok[0]     = '0;
    tok[0].vld = inject;
  end

  assign tail     = tok[MAX_FILES];
  assign tail_vld = tail.vld && (state_q == ST_SCAN);

  assign scan.n       = n_w;
  assign scan.start   = start_q;
  assign scan.now     = now_q;
  assign scan.timeout = tmo_q;

  // per-file commands: dispatch after the scan, release on completion
  always_comb begin
    cmd          = '0;
    cmd.size     = size_q;
    cmd.now      = now_q;
    cmd.dispatch = (state_q == ST_CMT) && (mode_q == MODE_REQUEST) && found_q;
    cmd.complete = (state_q == ST_CMT) && (mode_q == MODE_COMPLETE) && done_ok;
    cmd.idx      = (mode_q == MODE_COMPLETE) ? FW'(done_q) : best_q;
  end

  // the chain of file cells
  for (genvar g = 0; g < MAX_FILES; g++) begin : g_cell
    logic pool_b, open_b;
    if (g < MASK_W) begin : g_mapped
      assign pool_b = psel_q[g];
      assign open_b = open_q[g];
    end else begin : g_unmapped
      assign pool_b = 1'b0;
      assign open_b = 1'b0;
    end

    lufd_cell #(
      .FW  (FW),
      .NW  (NW),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1]),
      .scan_i    (scan),
      .cmd_i     (cmd),
      .pool_i    (pool_b),
      .open_i    (open_b),
      .timeout_o (to_bits[g])
    );
  end

  always_comb begin
    flags_w = '0;
    for (int f = 0; f < MAX_FILES; f++) begin
      if (f < MASK_W) begin
        flags_w[f] = to_bits[f];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == MODE_COMPLETE) begin
            state_d = ST_CMT;
          end else if (stream_ok && (n_w != '0)) begin
            state_d = ST_NORM;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_NORM: if (inject) state_d = ST_SCAN;
      ST_SCAN: begin
        if (tail_vld) begin
          state_d = tail.found ? ST_CMT : ST_FIN;
        end
      end
      ST_CMT:  state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < STREAMS; k++) begin
        sstart_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        found_q <= 1'b0;
      end else if (tail_vld) begin
        found_q <= tail.found;
      end
      // next start point goes to every stream whose pool holds it
      if (cmd.dispatch) begin
        for (int k = 0; k < STREAMS; k++) begin
          if ((32'(next_q) < MASK_W) && pool_q[k][next_q]) begin
            sstart_q[k] <= next_q;
          end
        end
      end
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_i.mode;
      size_q  <= in_i.block_size;
      tag_q   <= in_i.buffer_tag;
      now_q   <= in_i.now_time;
      done_q  <= in_i.done_file;
      psel_q  <= pool_q[SW'(in_i.stream_index)];
      start_q <= sstart_q[SW'(in_i.stream_index)];
    end else if ((state_q == ST_NORM) && !inject) begin
      // start point left over from a larger file count, reduce modulo the count
      start_q <= start_q - FW'(n_w);
    end
    if (tail_vld) begin
      best_q <= tail.best_idx;
      next_q <= tail.nx_idx;
    end
    if ((state_q == ST_FIN) && out_free) begin
      acc_q    <= found_q;
      chosen_q <= found_q ? CHOSEN_W'(best_q) : '0;
      osize_q  <= found_q ? size_q : '0;
      otag_q   <= found_q ? tag_q : '0;
      oflags_q <= flags_w;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.accepted        = acc_q;
  assign out_o.chosen_file     = chosen_q;
  assign out_o.dispatched_size = osize_q;
  assign out_o.dispatched_tag  = otag_q;
  assign out_o.timeout_flags   = oflags_q;

endmodule

`default_nettype wire

// ===== tb/lufd_tb_if.sv =====
// ----------------------------------------------------------------------------
// lufd testbench interfaces
// the channel interfaces come with the design; this file only sets the timescale
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for least_used_file_dispatcher
// ----------------------------------------------------------------------------
// Drives write requests and completions over the input channel with random
// gaps. The configuration registers are changed only while the block is
// idle. A model of the dispatcher kept in this file predicts each result,
// and the results from the block are compared with it in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import lufd_pkg::*;

  localparam int NFILES = 32;
  localparam int NSTREAMS = 4;
  localparam logic [47:0] COUNT_SAT = {48{1'b1}};

  typedef struct packed {
    logic                accepted;
    logic [CHOSEN_W-1:0] chosen_file;
    logic [SIZE_W-1:0]   dispatched_size;
    logic [TAG_W-1:0]    dispatched_tag;
    logic [MASK_W-1:0]   timeout_flags;
  } dispatch_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lufd_in_if  in_ch ();
  lufd_out_if out_ch ();
  lufd_cfg_if cfg_ch ();

  least_used_file_dispatcher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // copy of the register values and the block state
  logic [FCOUNT_W-1:0] m_file_count;
  logic [31:0]         m_pool [NSTREAMS];
  logic [31:0]         m_open;
  logic [31:0]         m_timeout;
  logic [47:0]         m_bytes [NFILES];
  logic [31:0]         m_busy;
  logic [31:0]         m_pending;
  logic [31:0]         m_start_time [NFILES];
  logic [4:0]          m_scan [NSTREAMS];
  logic [31:0]         m_tflags;

  dispatch_t expected_q[$];
  int  fail_count = 0;
  bit  hold_off = 1'b0;

  function automatic void model_reset();
    m_file_count = FILE_COUNT_RST;
    m_open = '0;
    m_timeout = TIMEOUT_RST;
    m_busy = '0;
    m_pending = '0;
    m_tflags = '0;
    for (int i = 0; i < NSTREAMS; i++) begin
      m_pool[i] = '0;
      m_scan[i] = '0;
    end
    for (int i = 0; i < NFILES; i++) begin
      m_bytes[i] = '0;
      m_start_time[i] = '0;
    end
  endfunction

  function automatic void model_write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_FILE_COUNT: m_file_count = val[FCOUNT_W-1:0];
      REG_POOL_0:     m_pool[0] = val;
      REG_POOL_1:     m_pool[1] = val;
      REG_POOL_2:     m_pool[2] = val;
      REG_POOL_3:     m_pool[3] = val;
      REG_OPEN_MASK:  m_open = val;
      REG_TIMEOUT:    m_timeout = val;
      default: ;
    endcase
  endfunction

  // completion release, least-loaded choice, timeout sweep and start point rotation
  function automatic dispatch_t predict_dispatch(logic mode, logic [1:0] s, logic [23:0] sz,
                                                 logic [15:0] tag, logic [31:0] now,
                                                 logic [4:0] done);
    dispatch_t r;
    int n, start, best, f, nxt;
    bit found;
    logic [47:0] best_cnt;
    logic [31:0] pool;
    r = '0;
    if (mode == MODE_COMPLETE) begin
      m_busy[done] = 1'b0;
      m_pending[done] = 1'b0;
      r.timeout_flags = m_tflags;
      return r;
    end
    n = (m_file_count > NFILES) ? NFILES : int'(m_file_count);
    if (n > 0) begin
      pool = m_pool[s];
      start = int'(m_scan[s]) % n;
      found = 1'b0;
      best = 0;
      best_cnt = '0;
      for (int i = 0; i < n; i++) begin
        f = (start + i) % n;
        if (pool[f] && m_open[f] && !m_busy[f]) begin
          if (!found || m_bytes[f] < best_cnt) begin
            found = 1'b1;
            best = f;
            best_cnt = m_bytes[f];
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        if (pool[i] && m_pending[i] &&
            {1'b0, now} > {1'b0, m_start_time[i]} + {1'b0, m_timeout}) begin
          m_tflags[i] = 1'b1;
          m_start_time[i] = now;
        end
      end
      if (found) begin
        m_busy[best] = 1'b1;
        m_pending[best] = 1'b1;
        m_start_time[best] = now;
        if (m_bytes[best] > COUNT_SAT - 48'(sz)) m_bytes[best] = COUNT_SAT;
        else m_bytes[best] = m_bytes[best] + 48'(sz);
        nxt = start;
        for (int i = 1; i <= n; i++) begin
          nxt = (start + i) % n;
          if (pool[nxt]) break;
        end
        for (int k = 0; k < NSTREAMS; k++)
          if (m_pool[k][nxt]) m_scan[k] = 5'(nxt);
        r.accepted = 1'b1;
        r.chosen_file = 5'(best);
        r.dispatched_size = sz;
        r.dispatched_tag = tag;
      end
    end
    r.timeout_flags = m_tflags;
    return r;
  endfunction

  // drives one transaction on the input channel and predicts its result;
  // valid stays high into the next call unless a gap or a drain drops it
  task automatic send_item(logic mode, logic [1:0] s, logic [23:0] sz, logic [15:0] tag,
                           logic [31:0] now, logic [4:0] done, bit gaps = 1'b1);
    int gap;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.stream_index <= s;
    in_ch.block_size <= sz;
    in_ch.buffer_tag <= tag;
    in_ch.now_time <= now;
    in_ch.done_file <= done;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(predict_dispatch(mode, s, sz, tag, now, done));
    @(negedge clk_i);
  endtask

  task automatic request(logic [1:0] s, logic [23:0] sz, logic [31:0] now);
    send_item(MODE_REQUEST, s, sz, 16'($urandom), now, 5'($urandom));
  endtask

  task automatic complete(logic [4:0] f);
    send_item(MODE_COMPLETE, 2'($urandom), 24'($urandom), 16'($urandom), $urandom, f);
  endtask

  // waits until every result has come, plus time for a block still at work
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.reg_data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    model_write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic setup(logic [5:0] cnt, logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                       logic [31:0] p3, logic [31:0] open, logic [31:0] tmo);
    drain();
    write_reg(REG_FILE_COUNT, 32'(cnt));
    write_reg(REG_POOL_0, p0);
    write_reg(REG_POOL_1, p1);
    write_reg(REG_POOL_2, p2);
    write_reg(REG_POOL_3, p3);
    write_reg(REG_OPEN_MASK, open);
    write_reg(REG_TIMEOUT, tmo);
    cfg_ch.valid <= 1'b0;
  endtask

  // ties, extremes, empty pools, completions, timeouts
  task automatic test_directed();
    setup(6'd32, '1, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0, '1, 32'd10);
    request(2'd0, 24'hFFFFFF, 32'd0);
    request(2'd0, 24'd0, 32'd5);
    request(2'd1, 24'd100, 32'd20);
    request(2'd3, 24'd100, 32'd20);                // empty pool
    complete(5'd0);
    complete(5'd31);
    request(2'd2, 24'd1, 32'hFFFF_FFFF);          // late time, but no pending file lies in this pool
    request(2'd0, 24'd7, 32'hFFFF_FFFF);
    send_item(MODE_REQUEST, 2'd1, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    send_item(MODE_REQUEST, 2'd2, 24'h0, 16'h0, 32'h0, 5'd0);
    for (int i = 0; i < 32; i++) complete(5'(i));
    // zero file count: nothing chosen
    setup(6'd0, '1, '1, '1, '1, '1, 32'd0);
    request(2'd0, 24'd5, 32'd50);
    // count above the maximum, largest timeout, time at both extremes
    setup(6'd63, '1, 32'h1, 32'h8000_0000, 32'hAAAA_5555, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
    request(2'd1, 24'd3, 32'd0);
    request(2'd2, 24'd3, 32'hFFFF_FFFF);
    request(2'd3, 24'd3, 32'd9);
    complete(5'd1);
    complete(5'd2);
  endtask

  // repeats maximum-size requests and completions on a single file
  task automatic test_saturation();
    setup(6'd1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h1, 32'd1000);
    for (int i = 0; i < 20; i++) begin
      request(2'(i % 2), 24'hFFFFFF, 32'(i));
      complete(5'd0);
    end
  endtask

  // random traffic over several register settings
  task automatic test_random(int count);
    logic [5:0] cnt;
    logic [31:0] now;
    for (int ph = 0; ph < 8; ph++) begin
      cnt = (ph == 0) ? 6'd1 : (ph == 1) ? 6'd32 : 6'($urandom_range(1, 40));
      setup(cnt, $urandom, $urandom, $urandom, $urandom,
            (ph == 2) ? '1 : ($urandom | $urandom),
            (ph == 3) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 300)));
      now = $urandom;
      for (int i = 0; i < count / 8; i++) begin
        now = now + 32'($urandom_range(0, 120));
        if ($urandom_range(0, 9) < 6)
          request(2'($urandom), ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                : 24'($urandom_range(0, 4096)), now);
        else
          complete(5'($urandom_range(0, 31)));
      end
    end
  endtask

  // the receiver holds off while the sender keeps going
  task automatic test_backpressure();
    setup(6'd4, 32'hF, 32'hF, 32'hF, 32'hF, 32'hF, 32'd50);
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 2) complete(5'($urandom_range(0, 3)));
      else request(2'($urandom), 24'($urandom_range(0, 999)), 32'(i * 40));
    end
    drain();
  endtask

  // sink: random stalls, one long hold-off, in-order compare
  initial begin
    dispatch_t got, exp_r;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
        stall = 0;
      end else begin
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (out_ch.valid) begin
        got = {out_ch.accepted, out_ch.chosen_file, out_ch.dispatched_size,
               out_ch.dispatched_tag, out_ch.timeout_flags};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.accepted !== exp_r.accepted) begin
            $display("%0t: accepted expected %0d got %0d", $time, exp_r.accepted, got.accepted);
            fail_count++;
          end
          if (got.chosen_file !== exp_r.chosen_file) begin
            $display("%0t: chosen_file expected %0d got %0d", $time,
                     exp_r.chosen_file, got.chosen_file);
            fail_count++;
          end
          if (got.dispatched_size !== exp_r.dispatched_size) begin
            $display("%0t: dispatched_size expected %h got %h", $time,
                     exp_r.dispatched_size, got.dispatched_size);
            fail_count++;
          end
          if (got.dispatched_tag !== exp_r.dispatched_tag) begin
            $display("%0t: dispatched_tag expected %h got %h", $time,
                     exp_r.dispatched_tag, got.dispatched_tag);
            fail_count++;
          end
          if (got.timeout_flags !== exp_r.timeout_flags) begin
            $display("%0t: timeout_flags expected %h got %h", $time,
                     exp_r.timeout_flags, got.timeout_flags);
            fail_count++;
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_REQUEST;
    in_ch.stream_index = '0;
    in_ch.block_size = '0;
    in_ch.buffer_tag = '0;
    in_ch.now_time = '0;
    in_ch.done_file = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_FILE_COUNT;
    cfg_ch.reg_data = '0;
    model_reset();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_saturation();
    test_backpressure();
    test_random(760);
    drain();
    if (fail_count == 0 && expected_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // run limit: ~900 items, with room for long stalls
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== least_used_file_dispatcher.f =====
design/lufd_pkg.sv
design/lufd_if.sv
design/lufd_cell.sv
design/least_used_file_dispatcher.sv
tb/lufd_tb_if.sv
tb/tb_top.sv
